>>> rtl/cpwc_pkg.sv
package cpwc_pkg;

  localparam int XW        = 12;
  localparam int YW        = 12;
  localparam int ValW      = 8;
  localparam int BprW      = 11;
  localparam int PcW       = 4;
  localparam int PeW       = 8;
  localparam int AddrW     = 22;
  localparam int WordW     = 32;
  localparam int SlotW     = 5;
  localparam int PlaneIdxW = 3;
  localparam int CfgIdxW   = 2;
  localparam int CfgW      = 11;

  localparam int DefMaxPlanes = 8;

  localparam logic [BprW-1:0] BprReset = 11'd40;
  localparam logic [PcW-1:0]  PcReset  = 4'd8;
  localparam logic [PeW-1:0]  PeReset  = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgBytesPerRow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlaneEnable = 2'd2;

  typedef struct packed {
    logic                   load;
    logic [AddrW-3:0]       word_sel;
    logic [WordW-1:0]       mask;
  } drain_ctl_t;

endpackage

>>> rtl/cpwc_in_if.sv
interface cpwc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [cpwc_pkg::XW-1:0]     pixel_x;
  logic [cpwc_pkg::YW-1:0]     pixel_y;
  logic [cpwc_pkg::ValW-1:0]   pixel_value;

  modport source(output valid, req_type, pixel_x, pixel_y, pixel_value, input ready);
  modport sink(input valid, req_type, pixel_x, pixel_y, pixel_value, output ready);
endinterface

>>> rtl/cpwc_out_if.sv
interface cpwc_out_if;
  logic                           valid;
  logic                           ready;
  logic [cpwc_pkg::PlaneIdxW-1:0] plane_index;
  logic [cpwc_pkg::AddrW-1:0]     word_addr;
  logic [cpwc_pkg::WordW-1:0]     plane_bits;
  logic [cpwc_pkg::WordW-1:0]     bit_mask;
  logic                           last_of_run;

  modport source(output valid, plane_index, word_addr, plane_bits, bit_mask, last_of_run,
                 input ready);
  modport sink(input valid, plane_index, word_addr, plane_bits, bit_mask, last_of_run,
               output ready);
endinterface

>>> rtl/cpwc_drain.sv
module cpwc_drain #(
  parameter int MAX_PLANES = cpwc_pkg::DefMaxPlanes
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cpwc_pkg::drain_ctl_t                    ctl,
  input  logic [MAX_PLANES-1:0]                   ctl_pend,
  input  logic [MAX_PLANES-1:0][cpwc_pkg::WordW-1:0] ctl_bits,
  output logic                                    free,
  cpwc_out_if.source                              words
);
  import cpwc_pkg::*;

  logic [MAX_PLANES-1:0]             pend;
  logic [MAX_PLANES-1:0][WordW-1:0]  bits;
  logic [WordW-1:0]                  mask;
  logic [AddrW-3:0]                  word_sel;

  logic                  ov;
  logic [PlaneIdxW-1:0]  o_idx;
  logic [AddrW-1:0]      o_addr;
  logic [WordW-1:0]      o_bits;
  logic [WordW-1:0]      o_mask;
  logic                  o_last;

  logic [MAX_PLANES-1:0] low;
  logic [PlaneIdxW-1:0]  low_idx;
  logic [WordW-1:0]      low_bits;
  logic                  emit;
  logic [MAX_PLANES-1:0] pend_after;

  always_comb begin
    low      = pend & (~pend + MAX_PLANES'(1));
    low_idx  = '0;
    low_bits = '0;
    for (int i = 0; i < MAX_PLANES; i++) begin
      if (low[i]) begin
        low_idx  = PlaneIdxW'(i);
        low_bits = bits[i];
      end
    end
  end

  assign emit       = (pend != '0) && (!ov || words.ready);
  assign pend_after = emit ? (pend & ~low) : pend;
  assign free       = (pend_after == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      ov   <= 1'b0;
    end else begin
      if (ctl.load) begin
        pend <= ctl_pend;
      end else begin
        pend <= pend_after;
      end
      if (emit) begin
        ov <= 1'b1;
      end else if (words.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bits     <= ctl_bits;
      mask     <= ctl.mask;
      word_sel <= ctl.word_sel;
    end
    if (emit) begin
      o_idx  <= low_idx;
      o_addr <= {word_sel, 2'b00};
      o_bits <= low_bits;
      o_mask <= mask;
      o_last <= ((pend & ~low) == '0);
    end
  end

  assign words.valid       = ov;
  assign words.plane_index = o_idx;
  assign words.word_addr   = o_addr;
  assign words.plane_bits  = o_bits;
  assign words.bit_mask    = o_mask;
  assign words.last_of_run = o_last;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst) ctl.load |-> free)
    else $error("Drain buffer loaded while still busy.");
  a_load_has_work: assert property (@(posedge clk) disable iff (rst) ctl.load |=> pend != '0)
    else $error("Drain buffer loaded with no plane to emit.");
  a_low_onehot: assert property (@(posedge clk) disable iff (rst) pend != '0 |-> $onehot(low))
    else $error("Plane selection is not a single plane.");

endmodule

>>> rtl/chunky_pixel_write_combiner_top.sv
// Channel | Dir | Fields                                                  | Accepted when
// pix     | in  | req_type, pixel_x, pixel_y, pixel_value                 | valid && ready
// words   | out | plane_index, word_addr, plane_bits, bit_mask, last_of_run | valid && ready
// cfg     | in  | cfg_we, cfg_index, cfg_data                             | cfg_we high
//
// A pixel write that hits the cached word merges into the cache, one item per cycle sustained.
// A miss or flush copies the cache into a drain buffer and keeps accepting; the drain buffer
// then emits one plane word per cycle through the output register while words.ready is high.
// Input stalls only when a second drain is needed before the buffer has emptied.
// Reset is synchronous; it empties the cache and the drain buffer and restores the registers.
module chunky_pixel_write_combiner_top #(
  parameter int MAX_PLANES = cpwc_pkg::DefMaxPlanes
) (
  input  logic                          clk,
  input  logic                          rst,
  cpwc_in_if.sink                       pix,
  cpwc_out_if.source                    words,
  input  logic                          cfg_we,
  input  logic [cpwc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cpwc_pkg::CfgW-1:0]     cfg_data
);
  import cpwc_pkg::*;

  logic [BprW-1:0] bytes_per_row;
  logic [PcW-1:0]  plane_count;
  logic [PeW-1:0]  plane_enable;

  logic             s1_valid;
  logic             s1_req;
  logic [AddrW-1:0] s1_off;
  logic [2:0]       s1_xlo;
  logic [ValW-1:0]  s1_val;

  logic [MAX_PLANES-1:0][WordW-1:0] plane_reg;
  logic [WordW-1:0]                 mask_reg;
  logic [AddrW-3:0]                 cached_sel;
  logic                             cache_valid;

  logic [AddrW:0]                   prod;
  logic [MAX_PLANES-1:0]            en_set;
  logic [MAX_PLANES-1:0][WordW-1:0] snap_bits;
  logic [SlotW-1:0]                 pos;
  logic                             miss;
  logic                             need;
  logic                             has_data;
  logic                             s1_go;
  logic                             free;
  drain_ctl_t                       ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_row <= BprReset;
      plane_count   <= PcReset;
      plane_enable  <= PeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgBytesPerRow: bytes_per_row <= cfg_data[BprW-1:0];
        CfgPlaneCount:  plane_count   <= cfg_data[PcW-1:0];
        CfgPlaneEnable: plane_enable  <= cfg_data[PeW-1:0];
        default: ;
      endcase
    end
  end

  assign prod = (AddrW+1)'(pix.pixel_y) * (AddrW+1)'(bytes_per_row)
              + (AddrW+1)'(pix.pixel_x[XW-1:3]);

  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      en_set[p]    = plane_enable[p] && (PcW'(p) < plane_count);
      snap_bits[p] = plane_reg[p] & mask_reg;
    end
  end

  assign pos      = ~{s1_off[1:0], s1_xlo};
  assign miss     = !cache_valid || (s1_off[AddrW-1:2] != cached_sel);
  assign need     = s1_req || miss;
  assign has_data = (mask_reg != '0) && (en_set != '0);
  assign s1_go    = s1_valid && !(need && has_data && !free);
  assign pix.ready = !s1_valid || s1_go;

  assign ctl.load     = s1_go && need && has_data;
  assign ctl.word_sel = cached_sel;
  assign ctl.mask     = mask_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      mask_reg    <= '0;
      cache_valid <= 1'b0;
    end else begin
      if (pix.ready) begin
        s1_valid <= pix.valid;
      end
      if (s1_go) begin
        if (s1_req) begin
          mask_reg    <= '0;
          cache_valid <= 1'b0;
        end else if (miss) begin
          mask_reg    <= WordW'(1) << pos;
          cache_valid <= 1'b1;
        end else begin
          mask_reg <= mask_reg | (WordW'(1) << pos);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      s1_req <= pix.req_type;
      s1_off <= prod[AddrW-1:0];
      s1_xlo <= pix.pixel_x[2:0];
      s1_val <= pix.pixel_value;
    end
    if (s1_go && !s1_req) begin
      if (miss) begin
        cached_sel <= s1_off[AddrW-1:2];
      end
      for (int p = 0; p < MAX_PLANES; p++) begin
        plane_reg[p][pos] <= s1_val[p];
      end
    end
  end

  cpwc_drain #(
    .MAX_PLANES(MAX_PLANES)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .ctl_pend (en_set),
    .ctl_bits (snap_bits),
    .free     (free),
    .words    (words)
  );

  a_mask_needs_valid: assert property (@(posedge clk) disable iff (rst)
    mask_reg != '0 |-> cache_valid)
    else $error("Written pixels held in an invalid cache.");
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !has_data) |-> s1_go)
    else $error("Item stalled although the cache holds nothing to drain.");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> s1_valid)
    else $error("Stalled item was lost.");

endmodule
